FILE: hw/rtl/stpxy_pkg.sv
// ----------------------------------------------------------------------------
// stpxy_pkg
// Shared constants, types and the half-degree sine table for the scan
// telegram polar-to-XY converter.
// ----------------------------------------------------------------------------
package stpxy_pkg;

  // Default sizing
  localparam int unsigned MAX_POINTS  = 361;
  localparam int unsigned COUNT_TOKEN = 25;

  // Telegram control bytes
  localparam logic [7:0] BYTE_STX   = 8'h02;
  localparam logic [7:0] BYTE_ETX   = 8'h03;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  localparam int unsigned TOKEN_W   = 6;
  localparam logic [TOKEN_W-1:0] TOKEN_IDLE = '1;

  localparam int unsigned RANGE_W   = 16;
  localparam int unsigned TRIG_W    = 16;   // magnitude 0..32768
  localparam int unsigned PROD_W    = RANGE_W + TRIG_W;
  localparam int unsigned MAG_W     = 21;
  localparam int unsigned INDEX_W   = 9;
  localparam int unsigned XPOS_W    = 21;
  localparam int unsigned YPOS_W    = 20;

  // Angle in half degrees; covers index up to 1023 plus the cosine offset
  localparam int unsigned ANGLE_W   = 11;
  localparam logic [ANGLE_W-1:0] ANGLE_FULL    = 11'd720;
  localparam logic [ANGLE_W-1:0] ANGLE_QUARTER = 11'd180;
  localparam logic [ANGLE_W-1:0] ANGLE_HALF    = 11'd360;
  localparam logic [ANGLE_W-1:0] ANGLE_3QTR    = 11'd540;

  localparam int unsigned ROM_LAST  = 180;
  localparam int unsigned ROM_IDX_W = 8;

  typedef logic [TRIG_W-1:0] sin_rom_t [ROM_LAST+1];

  typedef struct packed {
    logic                 neg;
    logic [ROM_IDX_W-1:0] idx;
  } trig_sel_t;

  // Table is built by rotating a Q2.30 unit vector in half-degree steps
  function automatic sin_rom_t build_sin_rom();
    longint c;
    longint s;
    longint nc;
    longint ns;
    longint v;
    longint unsigned q;
    sin_rom_t rom;
    c = 64'sd1073741824;
    s = 64'sd0;
    for (int k = 0; k <= ROM_LAST; k++) begin
      v = (s < 0) ? 64'sd0 : s;
      q = (longint'(v) + 64'sd16384) >>> 15;
      if (q > 64'd32768) q = 64'd32768;
      rom[k] = TRIG_W'(q);
      nc = (c * 64'sd1073700939 - s * 64'sd9370046 + 64'sd536870912) / 64'sd1073741824;
      ns = (s * 64'sd1073700939 + c * 64'sd9370046 + 64'sd536870912) / 64'sd1073741824;
      c = nc;
      s = ns;
    end
    return rom;
  endfunction

  localparam sin_rom_t SIN_ROM = build_sin_rom();

  // Quadrant fold: table slot and sign for a half-degree angle
  function automatic trig_sel_t trig_sel(logic [ANGLE_W-1:0] a_in);
    logic [ANGLE_W-1:0] a;
    trig_sel_t sel;
    a = (a_in >= ANGLE_FULL) ? a_in - ANGLE_FULL : a_in;
    if (a <= ANGLE_QUARTER) begin
      sel.neg = 1'b0;
      sel.idx = ROM_IDX_W'(a);
    end else if (a <= ANGLE_HALF) begin
      sel.neg = 1'b0;
      sel.idx = ROM_IDX_W'(ANGLE_HALF - a);
    end else if (a <= ANGLE_3QTR) begin
      sel.neg = 1'b1;
      sel.idx = ROM_IDX_W'(a - ANGLE_HALF);
    end else begin
      sel.neg = 1'b1;
      sel.idx = ROM_IDX_W'(ANGLE_FULL - a);
    end
    return sel;
  endfunction

endpackage

FILE: hw/rtl/scan_telegram_polar_to_xy.sv
// ----------------------------------------------------------------------------
// scan_telegram_polar_to_xy
// Parses an ASCII scanner telegram byte by byte and turns each range token
// into a point with X/Y in 1/16 mm at a fixed half-degree angular step.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------------------
//  in      | in_valid_i / in_stall_o | byte_in_i
//  out     | out_valid_o/out_stall_i | point_index_o, range_mm_o, x_pos_o,
//          |                         | y_pos_o, last_point_o
//
// One byte per cycle while in_stall_o is low. A point leaves through four
// registered stages after the separator or ETX beat that closes its range token: parse, table lookup, multiply, round.
// The four stages hold bubbles, so input keeps flowing while the output is
// stalled until all stages hold points. Reset leaves the parser as after STX.
// ----------------------------------------------------------------------------
module scan_telegram_polar_to_xy #(
  parameter int unsigned MaxPoints  = stpxy_pkg::MAX_POINTS,
  parameter int unsigned CountToken = stpxy_pkg::COUNT_TOKEN
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          byte_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [stpxy_pkg::INDEX_W-1:0]       point_index_o,
  output logic [stpxy_pkg::RANGE_W-1:0]       range_mm_o,
  output logic signed [stpxy_pkg::XPOS_W-1:0] x_pos_o,
  output logic [stpxy_pkg::YPOS_W-1:0]        y_pos_o,
  output logic                                last_point_o
);

  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned TokW = stpxy_pkg::TOKEN_W;
  localparam int unsigned RngW = stpxy_pkg::RANGE_W;
  localparam int unsigned TrgW = stpxy_pkg::TRIG_W;
  localparam int unsigned PrdW = stpxy_pkg::PROD_W;
  localparam int unsigned MagW = stpxy_pkg::MAG_W;
  localparam int unsigned IdxW = stpxy_pkg::INDEX_W;
  localparam int unsigned AngW = stpxy_pkg::ANGLE_W;

  // --------------------------------------------------------------------------
  // Flow control: each stage moves when it is empty or the next one moves
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  logic in_fire;

  assign en4        = !v4_q || !out_stall_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;
  assign in_fire    = in_valid_i && en1;

  // --------------------------------------------------------------------------
  // Parser
  // --------------------------------------------------------------------------
  logic [TokW-1:0] tok_q, tok_d;
  logic [RngW-1:0] acc_q, acc_d;
  logic            in_tok_q, in_tok_d;
  logic [CntW-1:0] exp_q, exp_d;
  logic [CntW-1:0] done_q, done_d;

  logic            is_hex;
  logic [3:0]      digit;
  logic            finish;
  logic            ev_fire;
  logic            ev_last;

  always_comb begin
    is_hex = 1'b1;
    digit  = 4'd0;
    if (byte_in_i >= "0" && byte_in_i <= "9") begin
      digit = 4'(byte_in_i - "0");
    end else if (byte_in_i >= "A" && byte_in_i <= "F") begin
      digit = 4'(byte_in_i - "A" + 8'd10);
    end else if (byte_in_i >= "a" && byte_in_i <= "f") begin
      digit = 4'(byte_in_i - "a" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign ev_last = ({1'b0, done_q} + 1'b1) == {1'b0, exp_q};

  always_comb begin
    tok_d    = tok_q;
    acc_d    = acc_q;
    in_tok_d = in_tok_q;
    exp_d    = exp_q;
    done_d   = done_q;
    finish   = 1'b0;
    ev_fire  = 1'b0;
    if (in_fire) begin
      if (byte_in_i == stpxy_pkg::BYTE_STX) begin
        tok_d    = '0;
        acc_d    = '0;
        in_tok_d = 1'b0;
        exp_d    = '0;
        done_d   = '0;
      end else if (byte_in_i == stpxy_pkg::BYTE_SPACE ||
                   byte_in_i == stpxy_pkg::BYTE_ETX) begin
        finish = in_tok_q;
      end else begin
        in_tok_d = 1'b1;
        if (is_hex) begin
          // saturate when a digit would push past 16 bits
          acc_d = (acc_q[RngW-1 -: 4] != 4'd0) ? '1 : {acc_q[RngW-5:0], digit};
        end
      end

      if (finish) begin
        if (tok_q == TokW'(CountToken)) begin
          exp_d  = (acc_q > RngW'(MaxPoints)) ? CntW'(MaxPoints) : CntW'(acc_q);
          done_d = '0;
        end else if (tok_q > TokW'(CountToken) && done_q < exp_q) begin
          ev_fire = 1'b1;
          done_d  = CntW'(done_q + 1'b1);
        end
        tok_d    = (tok_q == stpxy_pkg::TOKEN_IDLE) ? tok_q : tok_q + 1'b1;
        acc_d    = '0;
        in_tok_d = 1'b0;
      end

      if (byte_in_i == stpxy_pkg::BYTE_ETX) begin
        tok_d  = stpxy_pkg::TOKEN_IDLE;
        exp_d  = '0;
        done_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= '0;
      acc_q    <= '0;
      in_tok_q <= 1'b0;
      exp_q    <= '0;
      done_q   <= '0;
    end else begin
      tok_q    <= tok_d;
      acc_q    <= acc_d;
      in_tok_q <= in_tok_d;
      exp_q    <= exp_d;
      done_q   <= done_d;
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= ev_fire;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: point event
  // --------------------------------------------------------------------------
  logic [CntW-1:0] idx1_q;
  logic [RngW-1:0] rng1_q;
  logic            last1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      idx1_q  <= done_q;
      rng1_q  <= acc_q;
      last1_q <= ev_last;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: sine/cosine lookup
  // --------------------------------------------------------------------------
  logic [AngW-1:0]        ang_sin, ang_cos;
  stpxy_pkg::trig_sel_t   sel_sin, sel_cos;
  logic [TrgW-1:0]        sin2_q, cos2_q;
  logic                   sneg2_q, cneg2_q;
  logic [RngW-1:0]        rng2_q;
  logic [IdxW-1:0]        idx2_q;
  logic                   last2_q;

  assign ang_sin = AngW'(idx1_q);
  assign ang_cos = AngW'(idx1_q) + stpxy_pkg::ANGLE_QUARTER;
  assign sel_sin = stpxy_pkg::trig_sel(ang_sin);
  assign sel_cos = stpxy_pkg::trig_sel(ang_cos);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sin2_q  <= stpxy_pkg::SIN_ROM[sel_sin.idx];
      cos2_q  <= stpxy_pkg::SIN_ROM[sel_cos.idx];
      sneg2_q <= sel_sin.neg;
      cneg2_q <= sel_cos.neg;
      rng2_q  <= rng1_q;
      idx2_q  <= IdxW'(idx1_q);
      last2_q <= last1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: range times magnitude
  // --------------------------------------------------------------------------
  logic [PrdW-1:0] px3_q, py3_q;
  logic            xneg3_q, yneg3_q;
  logic [RngW-1:0] rng3_q;
  logic [IdxW-1:0] idx3_q;
  logic            last3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      px3_q   <= PrdW'(rng2_q) * PrdW'(cos2_q);
      py3_q   <= PrdW'(rng2_q) * PrdW'(sin2_q);
      xneg3_q <= cneg2_q;
      yneg3_q <= sneg2_q;
      rng3_q  <= rng2_q;
      idx3_q  <= idx2_q;
      last3_q <= last2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: round to 1/16 mm (x16 then >>15 is >>11), apply sign
  // --------------------------------------------------------------------------
  logic [PrdW:0]   sx, sy;
  logic [MagW-1:0] mx, my;
  logic [MagW-1:0] xs, ys;
  logic [MagW-1:0] x4_q, y4_q;
  logic [RngW-1:0] rng4_q;
  logic [IdxW-1:0] idx4_q;
  logic            last4_q;

  assign sx = {1'b0, px3_q} + (PrdW+1)'(1024);
  assign sy = {1'b0, py3_q} + (PrdW+1)'(1024);
  assign mx = MagW'(sx >> 11);
  assign my = MagW'(sy >> 11);
  assign xs = xneg3_q ? (~mx + 1'b1) : mx;
  assign ys = yneg3_q ? (~my + 1'b1) : my;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      x4_q    <= xs;
      y4_q    <= ys;
      rng4_q  <= rng3_q;
      idx4_q  <= idx3_q;
      last4_q <= last3_q;
    end
  end

  assign out_valid_o   = v4_q;
  assign point_index_o = idx4_q;
  assign range_mm_o    = rng4_q;
  assign x_pos_o       = signed'(x4_q);
  assign y_pos_o       = y4_q[stpxy_pkg::YPOS_W-1:0];
  assign last_point_o  = last4_q;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for scan_telegram_polar_to_xy: feeds telegram bytes
// through a valid/stall channel, predicts each point from its own parser
// and half-degree sine table or takes it from a typed row, and compares each output beat field by field.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [stpxy_pkg::INDEX_W-1:0]       idx;
    logic [stpxy_pkg::RANGE_W-1:0]       range_mm;
    logic signed [stpxy_pkg::XPOS_W-1:0] x_pos;
    logic [stpxy_pkg::YPOS_W-1:0]        y_pos;
    logic                                last;
  } point_t;

  typedef enum logic {CHK_MODEL, CHK_TYPED} chk_mode_e;

  typedef struct {
    string      body;
    logic [7:0] ender;
    int         reps;
    chk_mode_e  chk;
    point_t     pt;
  } stim_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] byte_in = 8'h00;
  logic out_stall = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic [stpxy_pkg::INDEX_W-1:0] point_index_o;
  logic [stpxy_pkg::RANGE_W-1:0] range_mm_o;
  logic signed [stpxy_pkg::XPOS_W-1:0] x_pos_o;
  logic [stpxy_pkg::YPOS_W-1:0] y_pos_o;
  logic last_point_o;

  scan_telegram_polar_to_xy i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .byte_in_i     (byte_in),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .point_index_o (point_index_o),
    .range_mm_o    (range_mm_o),
    .x_pos_o       (x_pos_o),
    .y_pos_o       (y_pos_o),
    .last_point_o  (last_point_o)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // predictor state
  longint      sine_tab [0:stpxy_pkg::ROM_LAST];
  int unsigned tok_cnt = 0;
  int unsigned hex_acc = 0;
  bit          in_tok = 1'b0;
  int unsigned pts_total = 0;
  int unsigned pts_sent = 0;

  point_t      pending_points[$];
  int          n_errors = 0;
  int          n_checked = 0;
  int          n_bytes = 0;
  int          n_points = 0;
  int          calm_left = 0;

  // Q2.30 unit vector rotated by half a degree per step
  function automatic void build_sine_tab();
    longint c, s, nc, ns, v, q;
    c = 64'sd1073741824;
    s = 64'sd0;
    for (int k = 0; k <= stpxy_pkg::ROM_LAST; k++) begin
      v = (s < 0) ? 64'sd0 : s;
      q = (v + 64'sd16384) >>> 15;
      if (q > 64'sd32768) q = 64'sd32768;
      sine_tab[k] = q;
      nc = (c * 64'sd1073700939 - s * 64'sd9370046 + 64'sd536870912) / 64'sd1073741824;
      ns = (s * 64'sd1073700939 + c * 64'sd9370046 + 64'sd536870912) / 64'sd1073741824;
      c = nc;
      s = ns;
    end
  endfunction

  function automatic longint signed_sine(int unsigned ang);
    int unsigned a;
    a = ang % 720;
    if (a <= 180) return sine_tab[a];
    if (a <= 360) return sine_tab[360 - a];
    if (a <= 540) return -sine_tab[a - 360];
    return -sine_tab[720 - a];
  endfunction

  // |r*t|*16 >> 15, round half away from zero, sign of t reapplied
  function automatic longint scaled(longint r, longint t);
    longint mag, q;
    mag = (t < 0) ? -t : t;
    q = (r * mag * 16 + 64'sd16384) >>> 15;
    return (t < 0) ? -q : q;
  endfunction

  function automatic void clear_scan();
    tok_cnt = 0;
    hex_acc = 0;
    in_tok = 1'b0;
    pts_total = 0;
    pts_sent = 0;
  endfunction

  function automatic bit close_token(output point_t pt);
    bit hit;
    longint xq, yq;
    hit = 1'b0;
    pt = '0;
    if (tok_cnt == stpxy_pkg::COUNT_TOKEN) begin
      pts_total = (hex_acc > stpxy_pkg::MAX_POINTS) ? stpxy_pkg::MAX_POINTS : hex_acc;
      pts_sent = 0;
    end else if (tok_cnt > stpxy_pkg::COUNT_TOKEN && pts_sent < pts_total) begin
      xq = scaled(hex_acc, signed_sine(pts_sent + 180));
      yq = scaled(hex_acc, signed_sine(pts_sent));
      pt.idx = pts_sent[stpxy_pkg::INDEX_W-1:0];
      pt.range_mm = hex_acc[stpxy_pkg::RANGE_W-1:0];
      pt.x_pos = xq[stpxy_pkg::XPOS_W-1:0];
      pt.y_pos = yq[stpxy_pkg::YPOS_W-1:0];
      pt.last = (pts_sent + 1 == pts_total);
      pts_sent++;
      hit = 1'b1;
    end
    if (tok_cnt < stpxy_pkg::TOKEN_IDLE) tok_cnt++;
    hex_acc = 0;
    in_tok = 1'b0;
    return hit;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output point_t pt);
    bit hit;
    int unsigned digit;
    pt = '0;
    if (b == stpxy_pkg::BYTE_STX) begin
      clear_scan();
      return 1'b0;
    end
    if (b == stpxy_pkg::BYTE_SPACE) return in_tok ? close_token(pt) : 1'b0;
    if (b == stpxy_pkg::BYTE_ETX) begin
      hit = in_tok ? close_token(pt) : 1'b0;
      tok_cnt = stpxy_pkg::TOKEN_IDLE;
      pts_total = 0;
      pts_sent = 0;
      return hit;
    end
    in_tok = 1'b1;
    if (b >= "0" && b <= "9") digit = b - "0";
    else if (b >= "A" && b <= "F") digit = b - "A" + 10;
    else if (b >= "a" && b <= "f") digit = b - "a" + 10;
    else return 1'b0;
    hex_acc = hex_acc * 16 + digit;
    if (hex_acc > 65535) hex_acc = 65535;
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  task automatic drive_byte(input logic [7:0] b);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 80);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in <= b;
    do @(posedge clk); while (in_stall_o);
    n_bytes++;
  endtask

  task automatic feed(input logic [7:0] b, input chk_mode_e chk, input point_t typed_pt);
    point_t pt;
    if (parse_byte(b, pt)) begin
      pending_points.push_back((chk == CHK_TYPED) ? typed_pt : pt);
      n_points++;
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      drive_byte(s[i]);
      feed(s[i], CHK_MODEL, '0);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    drive_byte(b);
    feed(b, CHK_MODEL, '0);
  endtask

  task automatic separators();
    repeat (($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1)
      send_byte(stpxy_pkg::BYTE_SPACE);
  endtask

  function automatic logic [7:0] token_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == stpxy_pkg::BYTE_STX || b == stpxy_pkg::BYTE_ETX ||
           b == stpxy_pkg::BYTE_SPACE);
    return b;
  endfunction

  // non-hex, non-separator, non-NUL
  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == stpxy_pkg::BYTE_STX || b == stpxy_pkg::BYTE_ETX ||
           b == stpxy_pkg::BYTE_SPACE ||
           (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f"));
    return b;
  endfunction

  function automatic string hex_text(int unsigned v);
    string s;
    s = $sformatf("%0h", v);
    if ($urandom_range(0, 3) == 0) s = {"0", s};
    if ($urandom_range(0, 1) == 1) s = s.toupper();
    if ($urandom_range(0, 9) == 0) s = $sformatf("%s%c", s, junk_byte());
    else if ($urandom_range(0, 19) == 0) s = $sformatf("%c%s", junk_byte(), s);
    return s;
  endfunction

  function automatic int unsigned range_value();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(65536, 1048575);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic random_telegram();
    int unsigned cnt, n_rng, roll;
    string s;
    bit closed;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      repeat ($urandom_range(4, 24)) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    // occasionally no STX: continues from whatever state the last telegram left
    if (roll != 1) send_byte(stpxy_pkg::BYTE_STX);
    repeat (stpxy_pkg::COUNT_TOKEN) begin
      repeat ($urandom_range(1, 3)) send_byte(token_byte());
      separators();
    end
    roll = $urandom_range(0, 19);
    if (roll == 0) cnt = 0;
    else if (roll == 1) cnt = $urandom_range(stpxy_pkg::MAX_POINTS + 1, 65535);
    else if (roll < 4) cnt = $urandom_range(11, 40);
    else cnt = $urandom_range(1, 10);
    send_text(hex_text(cnt));
    separators();
    n_rng = ((cnt > 40) ? 40 : cnt) + $urandom_range(0, 2);
    if (n_rng > 0 && $urandom_range(0, 7) == 0) n_rng = $urandom_range(0, n_rng - 1);
    closed = 1'b0;
    for (int k = 0; k < n_rng; k++) begin
      s = hex_text(range_value());
      if ($urandom_range(0, 24) == 0) begin
        // broken telegram: restart in the middle of a token
        send_text(s.substr(0, 0));
        send_byte(stpxy_pkg::BYTE_STX);
        return;
      end
      send_text(s);
      if (k == n_rng - 1 && $urandom_range(0, 1) == 1) begin
        send_byte(stpxy_pkg::BYTE_ETX);
        closed = 1'b1;
      end else begin
        separators();
      end
    end
    if (!closed && $urandom_range(0, 4) != 0) send_byte(stpxy_pkg::BYTE_ETX);
  endtask

  // output side: compare each accepted point with the oldest prediction
  function automatic void check_field(string name, logic [stpxy_pkg::XPOS_W-1:0] want,
                                      logic [stpxy_pkg::XPOS_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      n_checked++;
      if (pending_points.size() == 0) begin
        $display("%0t ns: unexpected point, expected none, got idx %0d range %0d",
                 $time, point_index_o, range_mm_o);
        n_errors++;
      end else begin
        want = pending_points.pop_front();
        check_field("point_index", stpxy_pkg::XPOS_W'(want.idx),
                    stpxy_pkg::XPOS_W'(point_index_o));
        check_field("range_mm", stpxy_pkg::XPOS_W'(want.range_mm),
                    stpxy_pkg::XPOS_W'(range_mm_o));
        check_field("x_pos", want.x_pos, x_pos_o);
        check_field("y_pos", stpxy_pkg::XPOS_W'(want.y_pos), stpxy_pkg::XPOS_W'(y_pos_o));
        check_field("last_point", stpxy_pkg::XPOS_W'(want.last),
                    stpxy_pkg::XPOS_W'(last_point_o));
      end
    end
  end

  // receiver stalls; one long hold-off so the pipeline backs up into the input
  initial begin : rx_stall_gen
    int run;
    bit held;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && n_checked >= 10) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        run = pick_gap();
        repeat ((run == 0) ? 1 : run) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin : stim
    stim_row_t dir_rows[$];
    stim_row_t row;
    dir_rows = '{
      // straight out of reset, no STX
      '{"0",      stpxy_pkg::BYTE_SPACE, 25, CHK_MODEL, '0},
      '{"3",      stpxy_pkg::BYTE_SPACE, 1,  CHK_MODEL, '0},
      '{"0",      stpxy_pkg::BYTE_SPACE, 1,  CHK_TYPED,
        '{9'd0, 16'd0, 21'sd0, 20'd0, 1'b0}},
      '{"FFFFF",  stpxy_pkg::BYTE_SPACE, 1,  CHK_MODEL, '0},   // saturates at 65535
      '{"1g2",    stpxy_pkg::BYTE_ETX,   1,  CHK_MODEL, '0},   // junk char skipped, last
      '{"7",      stpxy_pkg::BYTE_SPACE, 1,  CHK_MODEL, '0},   // idle after ETX
      // partial token dropped by STX, count clamped
      '{"AB",     stpxy_pkg::BYTE_STX,   1,  CHK_MODEL, '0},
      '{"zz",     stpxy_pkg::BYTE_SPACE, 2,  CHK_MODEL, '0},
      '{"0",      stpxy_pkg::BYTE_SPACE, 23, CHK_MODEL, '0},
      '{"fFfF",   stpxy_pkg::BYTE_SPACE, 1,  CHK_MODEL, '0},   // count clamps to MAX_POINTS
      '{"0",      stpxy_pkg::BYTE_SPACE, 1,  CHK_TYPED,
        '{9'd0, 16'd0, 21'sd0, 20'd0, 1'b0}},
      '{"2710  ", stpxy_pkg::BYTE_SPACE, 1,  CHK_MODEL, '0},   // run of separators
      '{"a",      stpxy_pkg::BYTE_SPACE, 20, CHK_MODEL, '0},
      '{"0",      stpxy_pkg::BYTE_SPACE, 1,  CHK_TYPED,
        '{9'd22, 16'd0, 21'sd0, 20'd0, 1'b0}},
      '{"FFFF",   stpxy_pkg::BYTE_ETX,   1,  CHK_MODEL, '0},
      // zero point count
      '{"",       stpxy_pkg::BYTE_STX,   1,  CHK_MODEL, '0},
      '{"0",      stpxy_pkg::BYTE_SPACE, 26, CHK_MODEL, '0},
      '{"5",      stpxy_pkg::BYTE_SPACE, 1,  CHK_MODEL, '0},
      '{"8",      stpxy_pkg::BYTE_ETX,   1,  CHK_MODEL, '0},
      // single point, then a surplus token closed by ETX
      '{"",       stpxy_pkg::BYTE_STX,   1,  CHK_MODEL, '0},
      '{"1",      stpxy_pkg::BYTE_SPACE, 26, CHK_MODEL, '0},
      '{"0",      stpxy_pkg::BYTE_SPACE, 1,  CHK_TYPED,
        '{9'd0, 16'd0, 21'sd0, 20'd0, 1'b1}},
      '{"9",      stpxy_pkg::BYTE_ETX,   1,  CHK_MODEL, '0},
      '{"",       stpxy_pkg::BYTE_ETX,   1,  CHK_MODEL, '0}
    };
    build_sine_tab();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      repeat (row.reps) begin
        for (int i = 0; i < row.body.len(); i++) begin
          drive_byte(row.body[i]);
          feed(row.body[i], row.chk, row.pt);
        end
        drive_byte(row.ender);
        feed(row.ender, row.chk, row.pt);
      end
    end

    while (n_bytes < 450) random_telegram();
    in_valid <= 1'b0;

    while (pending_points.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: scan_telegram_polar_to_xy.f
hw/rtl/stpxy_pkg.sv
hw/rtl/scan_telegram_polar_to_xy.sv
sim/tb.sv
